// ===== rtl/ssl_pkg.sv =====
`timescale 1ns / 1ps

package ssl_pkg;

    // Channel count and derived index width
    localparam int NUM_CHANNELS = 3;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CH_EXT_W     = 4;

    // Field widths
    localparam int SETP_W     = 8;
    localparam int PULSE_W    = 12;
    localparam int ANGLE_W    = 16;
    localparam int LEFT_W     = 15;
    localparam int MODE_W     = 2;
    localparam int CHAN_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Shared multiply / serial divide widths
    localparam int MUL_A_W   = 16;
    localparam int MUL_B_W   = 8;
    localparam int DIV_NUM_W = 24;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    // Setpoint constants
    localparam logic [SETP_W-1:0] SETP_CENTER = 8'd128;
    localparam logic [SETP_W-1:0] X_MIN       = 8'd20;
    localparam logic [SETP_W-1:0] X_MAX       = 8'd235;

    // Pulse mapping: s*75/16 + 900
    localparam logic [14:0]        PULSE_GAIN = 15'd75;
    localparam logic [PULSE_W-1:0] PULSE_BASE = 12'd900;

    // Register reset values
    localparam logic [SETP_W-1:0]  MAX_STEP_RST = 8'd6;
    localparam logic [SETP_W-1:0]  CENTER_RST   = 8'd0;
    localparam logic [LEFT_W-1:0]  LEFT_RST     = 15'd4909;
    localparam logic [ANGLE_W-1:0] RIGHT_RST    = 16'hEDA4;   // -4700

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK      = 2'd0,
        MODE_TARGET    = 2'd1,
        MODE_ANGLE_SET = 2'd2,
        MODE_ANGLE_GET = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_STEP = 2'd0,
        CFG_CENTER   = 2'd1,
        CFG_LEFT     = 2'd2,
        CFG_RIGHT    = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    // Pulse width count of one setpoint
    function automatic logic [PULSE_W-1:0] pulse_of(input logic [SETP_W-1:0] s);
        logic [14:0] prod;
        prod = {7'd0, s} * PULSE_GAIN;
        return {1'b0, prod[14:4]} + PULSE_BASE;
    endfunction

endpackage

// ===== rtl/ssl_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module ssl_div
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [ssl_pkg::DIV_NUM_W-1:0]    num,
    input  logic [ssl_pkg::DIV_DEN_W-1:0]    den,
    output logic                             done,
    output logic [ssl_pkg::DIV_NUM_W-1:0]    quot
);

    logic [ssl_pkg::DIV_NUM_W-1:0] quot_reg, quot_next;
    logic [ssl_pkg::DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [ssl_pkg::DIV_DEN_W-1:0] den_reg;
    logic [ssl_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          run_reg, run_next;
    logic                          done_reg, done_next;

    logic [ssl_pkg::DIV_DEN_W:0]   rem_sh;
    logic                          q_bit;

    // One shift / compare / subtract step
    always_comb
    begin
        rem_sh    = {rem_reg, quot_reg[ssl_pkg::DIV_NUM_W-1]};
        q_bit     = (rem_sh >= {1'b0, den_reg});
        rem_next  = q_bit ? ssl_pkg::DIV_DEN_W'(rem_sh - {1'b0, den_reg})
                          : rem_sh[ssl_pkg::DIV_DEN_W-1:0];
        quot_next = {quot_reg[ssl_pkg::DIV_NUM_W-2:0], q_bit};
        cnt_next  = cnt_reg + 1'b1;
        run_next  = run_reg && (cnt_reg != ssl_pkg::DIV_CNT_W'(ssl_pkg::DIV_NUM_W - 1));
        done_next = run_reg && (cnt_reg == ssl_pkg::DIV_CNT_W'(ssl_pkg::DIV_NUM_W - 1));
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            if (run_reg)
                cnt_reg <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (run_reg)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/servo_slew_limiter_with_angle_map_top.sv =====
`timescale 1ns / 1ps

// Channel  Handshake                  Payload
// -------  -------------------------  ---------------------------------------------
// cfg      cfg_wr_en                  cfg_index, cfg_data
// in       in_valid / in_ready        mode, channel, target_value, angle_in
// out      out_valid / out_ready      pulse_steer, pulse_second, pulse_third, angle_out
//
// Tick item: one channel per cycle through the step unit, then the finish state.
// Raw target item: straight to the finish state. Angle items: the multiply state, then
// the 24-step serial divider. One item is in flight; in_ready is high only when idle.
// The output register holds a result until taken; a stall there holds the next item
// in its last cycle. Reset: setpoints 128, registers at their defaults, no result.

module servo_slew_limiter_with_angle_map_top
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_wr_en,
    input  logic [ssl_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ssl_pkg::CFG_DATA_W-1:0]        cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [ssl_pkg::MODE_W-1:0]            mode,
    input  logic [ssl_pkg::CHAN_W-1:0]            channel,
    input  logic [ssl_pkg::SETP_W-1:0]            target_value,
    input  logic signed [ssl_pkg::ANGLE_W-1:0]    angle_in,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [ssl_pkg::PULSE_W-1:0]           pulse_steer,
    output logic [ssl_pkg::PULSE_W-1:0]           pulse_second,
    output logic [ssl_pkg::PULSE_W-1:0]           pulse_third,
    output logic signed [ssl_pkg::ANGLE_W-1:0]    angle_out
);

    localparam int NCH = ssl_pkg::NUM_CHANNELS;
    localparam int SW  = ssl_pkg::SETP_W;

    // Configuration registers
    logic [SW-1:0]                     max_step_reg;
    logic [SW-1:0]                     center_reg;
    logic [ssl_pkg::LEFT_W-1:0]        left_reg;
    logic signed [ssl_pkg::ANGLE_W-1:0] right_reg;

    // Setpoint state
    logic [SW-1:0] actual_reg [NCH];
    logic [SW-1:0] target_reg [NCH];

    // Sequencer
    ssl_pkg::state_t state_reg, state_next;
    ssl_pkg::mode_t  mode_reg;
    logic signed [ssl_pkg::ANGLE_W-1:0] angle_reg;
    logic [ssl_pkg::CH_IDX_W-1:0] ch_cnt_reg;
    logic branch_reg, zero_reg;

    // Output register
    logic                         out_valid_reg;
    logic [ssl_pkg::PULSE_W-1:0]  pulse_reg [3];
    logic [ssl_pkg::ANGLE_W-1:0]  angle_out_reg;

    // Strobes
    logic in_fire, tick_last, fin_fire, div_start, div_done;
    logic [ssl_pkg::DIV_NUM_W-1:0] div_quot;

    // ---------------- configuration write ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_step_reg <= ssl_pkg::MAX_STEP_RST;
            center_reg   <= ssl_pkg::CENTER_RST;
            left_reg     <= ssl_pkg::LEFT_RST;
            right_reg    <= ssl_pkg::RIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (ssl_pkg::cfg_idx_t'(cfg_index))
                ssl_pkg::CFG_MAX_STEP: max_step_reg <= cfg_data[SW-1:0];
                ssl_pkg::CFG_CENTER:   center_reg   <= cfg_data[SW-1:0];
                ssl_pkg::CFG_LEFT:     left_reg     <= cfg_data[ssl_pkg::LEFT_W-1:0];
                ssl_pkg::CFG_RIGHT:    right_reg    <= cfg_data;
            endcase
        end
    end

    // Center setpoint: 128 + signed offset, always 0..255
    logic [SW-1:0] c_pt;
    assign c_pt = {~center_reg[SW-1], center_reg[SW-2:0]};

    // Magnitude of the right limit
    logic [ssl_pkg::ANGLE_W-1:0] right_u, mag_r;
    assign right_u = right_reg;
    assign mag_r   = right_u[ssl_pkg::ANGLE_W-1] ? (~right_u + 1'b1) : right_u;

    // ---------------- state register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ssl_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ---------------- next state and strobes ----------------
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        in_fire    = 1'b0;
        div_start  = 1'b0;
        fin_fire   = 1'b0;
        tick_last  = (ch_cnt_reg == ssl_pkg::CH_IDX_W'(NCH - 1));
        unique case (state_reg)
            ssl_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                in_fire  = in_valid;
                if (in_valid)
                begin
                    unique case (ssl_pkg::mode_t'(mode))
                        ssl_pkg::MODE_TICK:      state_next = ssl_pkg::ST_TICK;
                        ssl_pkg::MODE_TARGET:    state_next = ssl_pkg::ST_FIN;
                        ssl_pkg::MODE_ANGLE_SET: state_next = ssl_pkg::ST_MUL;
                        ssl_pkg::MODE_ANGLE_GET: state_next = ssl_pkg::ST_MUL;
                    endcase
                end
            end
            ssl_pkg::ST_TICK:
            begin
                if (tick_last)
                    state_next = ssl_pkg::ST_FIN;
            end
            ssl_pkg::ST_MUL:
            begin
                div_start  = 1'b1;
                state_next = ssl_pkg::ST_DIV;
            end
            ssl_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = ssl_pkg::ST_FIN;
            end
            ssl_pkg::ST_FIN:
            begin
                fin_fire = !out_valid_reg || out_ready;
                if (fin_fire)
                    state_next = ssl_pkg::ST_IDLE;
            end
            default: state_next = ssl_pkg::ST_IDLE;
        endcase
    end

    // ---------------- operand select for the shared multiply/divide ----------------
    logic [ssl_pkg::MUL_A_W-1:0]   mul_a;
    logic [ssl_pkg::MUL_B_W-1:0]   mul_b;
    logic [ssl_pkg::DIV_DEN_W-1:0] div_den;
    logic                          op_branch, op_zero;
    logic [ssl_pkg::LEFT_W-1:0]    a_pos, a_left;
    logic signed [ssl_pkg::ANGLE_W-1:0] a_right;
    logic [ssl_pkg::ANGLE_W-1:0]   a_right_u, mag_a;
    logic [SW-1:0]                 t0;

    always_comb
    begin
        t0        = target_reg[0];
        a_pos     = angle_reg[ssl_pkg::LEFT_W-1:0];
        a_left    = (a_pos > left_reg) ? left_reg : a_pos;
        a_right   = (angle_reg < right_reg) ? right_reg : angle_reg;
        a_right_u = a_right;
        mag_a     = a_right_u[ssl_pkg::ANGLE_W-1] ? (~a_right_u + 1'b1) : a_right_u;
        if (mode_reg == ssl_pkg::MODE_ANGLE_SET)
        begin
            op_branch = angle_reg[ssl_pkg::ANGLE_W-1];
            if (!op_branch)
            begin
                // left: (L - a) * c / L
                mul_a   = {1'b0, left_reg - a_left};
                mul_b   = c_pt;
                div_den = {1'b0, left_reg};
                op_zero = (left_reg == '0);
            end
            else
            begin
                // right: (255 - c) * |a| / |R|
                mul_a   = mag_a;
                mul_b   = ~c_pt;
                div_den = mag_r;
                op_zero = (mag_r == '0);
            end
        end
        else
        begin
            op_branch = (t0 > c_pt);
            if (!op_branch)
            begin
                // low side: L * t / c
                mul_a   = {1'b0, left_reg};
                mul_b   = t0;
                div_den = {8'd0, c_pt};
                op_zero = (c_pt == '0);
            end
            else
            begin
                // high side: |R| * (t - c) / (255 - c)
                mul_a   = mag_r;
                mul_b   = t0 - c_pt;
                div_den = {8'd0, ~c_pt};
                op_zero = 1'b0;
            end
        end
    end

    logic [ssl_pkg::DIV_NUM_W-1:0] mul_prod;
    assign mul_prod = ssl_pkg::DIV_NUM_W'(mul_a) * ssl_pkg::DIV_NUM_W'(mul_b);

    ssl_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mul_prod),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // ---------------- slew step for one channel ----------------
    logic [SW-1:0] step_a, step_t, step_res;
    logic [SW:0]   a_plus_m, t_plus_m;

    always_comb
    begin
        step_a   = actual_reg[ch_cnt_reg];
        step_t   = target_reg[ch_cnt_reg];
        a_plus_m = {1'b0, step_a} + {1'b0, max_step_reg};
        t_plus_m = {1'b0, step_t} + {1'b0, max_step_reg};
        priority if ({1'b0, step_a} > t_plus_m)
            step_res = step_a - max_step_reg;
        else if (a_plus_m < {1'b0, step_t})
            step_res = a_plus_m[SW-1:0];
        else
            step_res = step_t;
    end

    // ---------------- result formation ----------------
    logic [SW:0]                 x_sum;
    logic [SW-1:0]               x_pre, x_clamp;
    logic [ssl_pkg::ANGLE_W-1:0] q16, angle_res;

    always_comb
    begin
        q16 = div_quot[ssl_pkg::ANGLE_W-1:0];
        if (!branch_reg)
            x_sum = {1'b0, zero_reg ? c_pt : div_quot[SW-1:0]};
        else
            x_sum = {1'b0, zero_reg ? {SW{1'b0}} : div_quot[SW-1:0]} + {1'b0, c_pt};
        x_pre = x_sum[SW-1:0];
        priority if (x_pre < ssl_pkg::X_MIN)
            x_clamp = ssl_pkg::X_MIN;
        else if (x_pre > ssl_pkg::X_MAX)
            x_clamp = ssl_pkg::X_MAX;
        else
            x_clamp = x_pre;

        if (mode_reg != ssl_pkg::MODE_ANGLE_GET)
            angle_res = '0;
        else if (!branch_reg)
            angle_res = {1'b0, zero_reg ? left_reg
                                        : left_reg - div_quot[ssl_pkg::LEFT_W-1:0]};
        else
            angle_res = right_u[ssl_pkg::ANGLE_W-1] ? (~q16 + 1'b1) : q16;
    end

    // ---------------- item latch, counter, flags ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= ssl_pkg::MODE_TICK;
            ch_cnt_reg <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                mode_reg   <= ssl_pkg::mode_t'(mode);
                ch_cnt_reg <= '0;
            end
            else if (state_reg == ssl_pkg::ST_TICK && !tick_last)
                ch_cnt_reg <= ch_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            angle_reg <= angle_in;
        if (div_start)
        begin
            branch_reg <= op_branch;
            zero_reg   <= op_zero;
        end
    end

    // ---------------- setpoint state ----------------
    logic [ssl_pkg::CH_EXT_W-1:0] chan_ext;
    assign chan_ext = {2'b00, channel};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCH; i++)
            begin
                actual_reg[i] <= ssl_pkg::SETP_CENTER;
                target_reg[i] <= ssl_pkg::SETP_CENTER;
            end
        end
        else
        begin
            if (state_reg == ssl_pkg::ST_TICK)
                actual_reg[ch_cnt_reg] <= step_res;
            if (in_fire && ssl_pkg::mode_t'(mode) == ssl_pkg::MODE_TARGET
                && chan_ext < ssl_pkg::CH_EXT_W'(NCH))
                target_reg[chan_ext[ssl_pkg::CH_IDX_W-1:0]] <= target_value;
            else if (fin_fire && mode_reg == ssl_pkg::MODE_ANGLE_SET)
                target_reg[0] <= x_clamp;
        end
    end

    // ---------------- output register ----------------
    logic [ssl_pkg::PULSE_W-1:0] pulse_now [3];

    for (genvar g = 0; g < 3; g++)
    begin : g_pulse
        if (g < NCH)
        begin : g_live
            assign pulse_now[g] = ssl_pkg::pulse_of(actual_reg[g]);
        end
        else
        begin : g_absent
            assign pulse_now[g] = ssl_pkg::PULSE_BASE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fin_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fin_fire)
        begin
            for (int i = 0; i < 3; i++)
                pulse_reg[i] <= pulse_now[i];
            angle_out_reg <= angle_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pulse_steer  = pulse_reg[0];
    assign pulse_second = pulse_reg[1];
    assign pulse_third  = pulse_reg[2];
    assign angle_out    = angle_out_reg;

    // ---------------- assertions ----------------
    a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ssl_pkg::ST_DIV)
        else $error("divider finished outside the divide state");

    a_tick_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ssl_pkg::ST_TICK |-> ch_cnt_reg <= ssl_pkg::CH_IDX_W'(NCH - 1))
        else $error("channel counter past last channel");

    a_steer_target_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_fire && mode_reg == ssl_pkg::MODE_ANGLE_SET)
        |=> (target_reg[0] >= ssl_pkg::X_MIN && target_reg[0] <= ssl_pkg::X_MAX))
        else $error("steering target outside clamp range");

    a_angle_zero_other_modes: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_fire && mode_reg != ssl_pkg::MODE_ANGLE_GET) |=> angle_out == '0)
        else $error("angle_out nonzero outside angle read");

endmodule
